// File: rtl/core/svbpf_pkg.sv
// Servo bus packet framer: shared types, constants and codes.
// Used by every module of the framer; depends on nothing.
package svbpf_pkg;

  // Command codes on the input request
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_PARAM = 1'b1;

  // Error codes on results
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_BAD_ID   = 3'd1;
  localparam logic [2:0] ERR_TOO_MANY = 3'd2;
  localparam logic [2:0] ERR_CAPACITY = 3'd3;
  localparam logic [2:0] ERR_STRAY    = 3'd4;

  // Frame constants
  localparam logic [7:0] HEADER_BYTE    = 8'hFF;
  localparam logic [7:0] BROADCAST_ID   = 8'hFE;
  localparam logic [7:0] MAX_PARAMS     = 8'd251;
  localparam logic [8:0] FRAME_OVERHEAD = 9'd6;
  localparam logic [7:0] LENGTH_BIAS    = 8'd2;
  localparam logic [8:0] CAPACITY_RESET = 9'd257;

  // Job queue sizing
  localparam int unsigned JOB_QUEUE_DEPTH = 4;

  // Byte positions within a job's burst
  localparam logic [2:0] STEP_HDR0  = 3'd0;
  localparam logic [2:0] STEP_HDR1  = 3'd1;
  localparam logic [2:0] STEP_ID    = 3'd2;
  localparam logic [2:0] STEP_LEN   = 3'd3;
  localparam logic [2:0] STEP_INSTR = 3'd4;
  localparam logic [2:0] STEP_CKS   = 3'd5;

  // What the back end must emit for one accepted request
  typedef enum logic [2:0] {
    JOB_ERROR,   // one error result
    JOB_OPEN,    // header, id, length, instruction
    JOB_FULL,    // as JOB_OPEN, then checksum (no parameters)
    JOB_PARAM,   // one parameter byte
    JOB_CLOSE    // last parameter byte, then checksum
  } job_kind_e;

  typedef struct packed {
    job_kind_e  kind;
    logic [2:0] err;
    logic [7:0] data;   // servo id, or parameter byte
    logic [7:0] len;
    logic [7:0] instr;
    logic [7:0] cks;
  } job_t;

endpackage

// File: rtl/core/servo_bus_packet_framer_top.sv
// Servo bus instruction packet framer, top level.
// Depends on svbpf_pkg, svbpf_front, svbpf_job_fifo and svbpf_back.
//
// Accepts start and parameter requests through a queue-style port and
// delivers the instruction packet as a byte stream through another. A front
// end checks each request in the cycle it is accepted and posts one job into
// a short job queue (JobQueueDepth entries); a back end turns each job into
// bytes into an output register, one per cycle unless held by pop. Parameter
// requests are taken one per cycle while not full, each giving one byte, the
// last parameter two (its byte and the checksum); a start request five
// bytes, six with no parameters, and an error one. full rises only when the
// job queue is full, so a burst of bytes drains while new requests arrive.
// The capacity register is written through cfg_valid_i/cfg_ready_o, which is
// always ready; write it only while the framer is idle.
module servo_bus_packet_framer_top #(
  parameter int unsigned JobQueueDepth = svbpf_pkg::JOB_QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic       command_i,
  input  logic [7:0] target_id_i,
  input  logic [7:0] instruction_i,
  input  logic [7:0] param_count_i,
  input  logic [7:0] param_byte_i,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] out_byte_o,
  output logic       last_of_packet_o,
  output logic [2:0] error_code_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [8:0] cfg_data_i
);

  svbpf_pkg::job_t front_job, back_job;
  logic            accept, job_valid, job_done;

  assign accept      = push && !full;
  assign cfg_ready_o = 1'b1;

  // Classify requests
  svbpf_front u_front (
    .clk_i,
    .rst_ni,
    .accept_i      (accept),
    .command_i,
    .target_id_i,
    .instruction_i,
    .param_count_i,
    .param_byte_i,
    .cfg_write_i   (cfg_valid_i),
    .cfg_data_i,
    .job_o         (front_job)
  );

  // Queue jobs between the two ends
  svbpf_job_fifo #(
    .Depth (JobQueueDepth)
  ) u_job_fifo (
    .clk_i,
    .rst_ni,
    .wr_i     (accept),
    .wr_job_i (front_job),
    .full_o   (full),
    .rd_i     (job_done),
    .rd_job_o (back_job),
    .valid_o  (job_valid)
  );

  // Emit packet bytes
  svbpf_back u_back (
    .clk_i,
    .rst_ni,
    .job_valid_i (job_valid),
    .job_i       (back_job),
    .job_done_o  (job_done),
    .pop,
    .empty,
    .out_byte_o,
    .last_of_packet_o,
    .error_code_o
  );

endmodule

// File: rtl/core/svbpf_front.sv
// Servo bus packet framer front end: checks requests, tracks the open packet
// and turns each accepted request into one job. Depends on svbpf_pkg.
module svbpf_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic                command_i,
  input  logic [7:0]          target_id_i,
  input  logic [7:0]          instruction_i,
  input  logic [7:0]          param_count_i,
  input  logic [7:0]          param_byte_i,
  input  logic                cfg_write_i,
  input  logic [8:0]          cfg_data_i,
  output svbpf_pkg::job_t     job_o
);

  logic       open_q, open_d;
  logic [7:0] left_q, left_d;
  logic [7:0] sum_q, sum_d;
  logic [8:0] capacity_q;

  logic       bad_id, too_many, over_cap;
  logic [7:0] len, start_sum, left_dec, param_sum;

  // Check a start request and precompute the start and parameter sums
  always_comb begin
    bad_id    = target_id_i > svbpf_pkg::BROADCAST_ID;
    too_many  = param_count_i > svbpf_pkg::MAX_PARAMS;
    over_cap  = ({1'b0, param_count_i} + svbpf_pkg::FRAME_OVERHEAD) > capacity_q;
    len       = param_count_i + svbpf_pkg::LENGTH_BIAS;
    start_sum = target_id_i + len + instruction_i;
    left_dec  = left_q - 8'd1;
    param_sum = sum_q + param_byte_i;
  end

  // Classify the request and work out the next packet state
  always_comb begin
    open_d = open_q;
    left_d = left_q;
    sum_d  = sum_q;
    job_o.kind  = svbpf_pkg::JOB_ERROR;
    job_o.err   = svbpf_pkg::ERR_NONE;
    job_o.data  = target_id_i;
    job_o.len   = len;
    job_o.instr = instruction_i;
    job_o.cks   = ~start_sum;
    if (command_i == svbpf_pkg::CMD_START) begin
      // any start abandons an open packet
      open_d = 1'b0;
      left_d = 8'd0;
      sum_d  = 8'd0;
      if (bad_id) begin
        job_o.err = svbpf_pkg::ERR_BAD_ID;
      end else if (too_many) begin
        job_o.err = svbpf_pkg::ERR_TOO_MANY;
      end else if (over_cap) begin
        job_o.err = svbpf_pkg::ERR_CAPACITY;
      end else if (param_count_i == 8'd0) begin
        job_o.kind = svbpf_pkg::JOB_FULL;
      end else begin
        job_o.kind = svbpf_pkg::JOB_OPEN;
        open_d = 1'b1;
        left_d = param_count_i;
        sum_d  = start_sum;
      end
    end else if (!open_q) begin
      job_o.err = svbpf_pkg::ERR_STRAY;
    end else begin
      job_o.data = param_byte_i;
      job_o.cks  = ~param_sum;
      if (left_dec == 8'd0) begin
        job_o.kind = svbpf_pkg::JOB_CLOSE;
        open_d = 1'b0;
        left_d = 8'd0;
        sum_d  = 8'd0;
      end else begin
        job_o.kind = svbpf_pkg::JOB_PARAM;
        left_d = left_dec;
        sum_d  = param_sum;
      end
    end
  end

  // Advance packet state on each accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      left_q <= 8'd0;
      sum_q  <= 8'd0;
    end else if (accept_i) begin
      open_q <= open_d;
      left_q <= left_d;
      sum_q  <= sum_d;
    end
  end

  // Hold the capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= svbpf_pkg::CAPACITY_RESET;
    end else if (cfg_write_i) begin
      capacity_q <= cfg_data_i;
    end
  end

endmodule

// File: rtl/core/svbpf_job_fifo.sv
// Servo bus packet framer job queue between front and back end.
// Depends on svbpf_pkg for the job type.
module svbpf_job_fifo #(
  parameter int unsigned Depth = svbpf_pkg::JOB_QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_i,
  input  svbpf_pkg::job_t wr_job_i,
  output logic            full_o,
  input  logic            rd_i,
  output svbpf_pkg::job_t rd_job_o,
  output logic            valid_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  svbpf_pkg::job_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o   = count_q == CntW'(Depth);
  assign valid_o  = count_q != '0;
  assign rd_job_o = mem_q[rd_ptr_q];

  // Store incoming jobs
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_job_i;
    end
  end

  // Advance pointers and the fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (rd_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (wr_i && !rd_i) begin
        count_q <= count_q + 1'b1;
      end else if (rd_i && !wr_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/svbpf_back.sv
// Servo bus packet framer back end: expands each job into its bytes and
// holds them in the output register. Depends on svbpf_pkg.
module svbpf_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            job_valid_i,
  input  svbpf_pkg::job_t job_i,
  output logic            job_done_o,
  input  logic            pop,
  output logic            empty,
  output logic [7:0]      out_byte_o,
  output logic            last_of_packet_o,
  output logic [2:0]      error_code_o
);

  logic       out_valid_q;
  logic [7:0] byte_q, byte_d;
  logic       last_q, last_d;
  logic [2:0] err_q;
  logic [2:0] step_q, last_step;
  logic       advance, load;

  assign empty            = !out_valid_q;
  assign out_byte_o       = byte_q;
  assign last_of_packet_o = last_q;
  assign error_code_o     = err_q;

  assign advance    = !out_valid_q || pop;
  assign load       = advance && job_valid_i;
  assign job_done_o = load && (step_q == last_step);

  // Select the byte for the current step of the job
  always_comb begin
    last_step = svbpf_pkg::STEP_HDR0;
    byte_d    = 8'd0;
    last_d    = 1'b0;
    case (job_i.kind) inside
      svbpf_pkg::JOB_ERROR: begin
        last_d = 1'b1;
      end
      svbpf_pkg::JOB_OPEN, svbpf_pkg::JOB_FULL: begin
        last_step = (job_i.kind == svbpf_pkg::JOB_FULL) ? svbpf_pkg::STEP_CKS
                                                        : svbpf_pkg::STEP_INSTR;
        case (step_q)
          svbpf_pkg::STEP_ID:    byte_d = job_i.data;
          svbpf_pkg::STEP_LEN:   byte_d = job_i.len;
          svbpf_pkg::STEP_INSTR: byte_d = job_i.instr;
          svbpf_pkg::STEP_CKS: begin
            byte_d = job_i.cks;
            last_d = 1'b1;
          end
          default:               byte_d = svbpf_pkg::HEADER_BYTE;
        endcase
      end
      svbpf_pkg::JOB_CLOSE: begin
        last_step = svbpf_pkg::STEP_HDR1;
        if (step_q == svbpf_pkg::STEP_HDR1) begin
          byte_d = job_i.cks;
          last_d = 1'b1;
        end else begin
          byte_d = job_i.data;
        end
      end
      default: begin
        byte_d = job_i.data;
      end
    endcase
  end

  // Step through the job's bytes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= svbpf_pkg::STEP_HDR0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        step_q <= job_done_o ? svbpf_pkg::STEP_HDR0 : step_q + 3'd1;
      end
      if (advance) begin
        out_valid_q <= job_valid_i;
      end
    end
  end

  // Load the output register
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= byte_d;
      last_q <= last_d;
      err_q  <= job_i.err;
    end
  end

endmodule
